// ===== src/sqvs_pkg.sv =====
// shared types, constants and table functions for the sprite quad vertex setup
// no dependencies
package sqvs_pkg;

  localparam int SineTableDepth = 256;
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  localparam int NumVerts = 6;
  localparam logic [2:0] LastCorner = 3'd5;
  localparam int DivBits = 28;
  localparam int DivStep = 4;
  localparam int DivStages = DivBits / DivStep;
  localparam int PipeDepth = 8;
  localparam logic [63:0] SineDiv [7] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
                                          64'd210};

  // register map, index taken from paddr bit 2
  typedef enum logic {
    RegTexWidth  = 1'b0,
    RegTexHeight = 1'b1
  } reg_idx_e;

  typedef logic signed [23:0] coord_t;
  typedef logic signed [17:0] texc_t;
  typedef logic signed [17:0] trig_t;

  // four distinct corners, index = col + 2*row
  typedef struct packed {
    coord_t [3:0] x;
    coord_t [3:0] y;
  } quad_pos_t;

  typedef struct packed {
    logic [12:0] tex_width;
    logic [12:0] tex_height;
  } tex_cfg_t;

  // quarter-wave entry from the table position p = i * 2^32 / depth
  function automatic logic [16:0] quarter_sine(input logic [63:0] p);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] sum;
    logic [63:0] r;
    x = (p * HalfPiQ30) >> 32;
    x2 = (x * x) >> 30;
    t = x;
    sum = x;
    for (int k = 1; k <= 7; k++) begin
      t = ((t * x2) >> 30) / SineDiv[k-1];
      if (k % 2 == 1) sum = sum - t;
      else sum = sum + t;
    end
    r = (sum + 64'd8192) >> 14;
    if (r > 64'd65536) r = 64'd65536;
    return r[16:0];
  endfunction

  function automatic logic corner_col(input logic [2:0] k);
    case (k)
      3'd1, 3'd3, 3'd4: return 1'b1;
      default:          return 1'b0;
    endcase
  endfunction

  function automatic logic corner_row(input logic [2:0] k);
    case (k)
      3'd2, 3'd4, 3'd5: return 1'b1;
      default:          return 1'b0;
    endcase
  endfunction

endpackage

// ===== src/sqvs_if.sv =====
// word channels of the sprite quad vertex setup: sprite in, vertex out
// no dependencies
interface sqvs_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] src_left;
  logic [11:0] src_top;
  logic [11:0] src_right;
  logic [11:0] src_bottom;
  logic signed [23:0] dst_left;
  logic signed [23:0] dst_top;
  logic signed [23:0] dst_right;
  logic signed [23:0] dst_bottom;
  logic [31:0] tint_argb;
  logic [15:0] rotation;
  logic signed [23:0] offset_x;
  logic signed [23:0] offset_y;

  modport source(output valid, src_left, src_top, src_right, src_bottom, dst_left, dst_top,
                 dst_right, dst_bottom, tint_argb, rotation, offset_x, offset_y,
                 input ready);
  modport sink(input valid, src_left, src_top, src_right, src_bottom, dst_left, dst_top,
               dst_right, dst_bottom, tint_argb, rotation, offset_x, offset_y,
               output ready);
endinterface

interface sqvs_out_if;
  logic        valid;
  logic        ready;
  logic signed [23:0] vertex_x;
  logic signed [23:0] vertex_y;
  logic signed [17:0] tex_u;
  logic signed [17:0] tex_v;
  logic [31:0] color_rgba;
  logic [2:0]  corner;
  logic        last_vertex;

  modport source(output valid, vertex_x, vertex_y, tex_u, tex_v, color_rgba, corner,
                 last_vertex, input ready);
  modport sink(input valid, vertex_x, vertex_y, tex_u, tex_v, color_rgba, corner,
               last_vertex, output ready);
endinterface

// ===== src/sqvs_cfg.sv =====
// apb register file holding texture width and height
// depends on sqvs_pkg
module sqvs_cfg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output sqvs_pkg::tex_cfg_t cfg_o
);
  logic [12:0] width_q, height_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd1;
      height_q <= 13'd1;
    end else if (wr_en) begin
      case (sqvs_pkg::reg_idx_e'(paddr[2]))
        sqvs_pkg::RegTexWidth:  width_q  <= pwdata[12:0];
        sqvs_pkg::RegTexHeight: height_q <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sqvs_pkg::reg_idx_e'(paddr[2]))
      sqvs_pkg::RegTexWidth:  prdata = {19'd0, width_q};
      sqvs_pkg::RegTexHeight: prdata = {19'd0, height_q};
      default:                prdata = 32'd0;
    endcase
  end

  // a zero size acts as one
  assign cfg_o.tex_width  = (width_q == 13'd0) ? 13'd1 : width_q;
  assign cfg_o.tex_height = (height_q == 13'd0) ? 13'd1 : height_q;
endmodule

// ===== src/sqvs_sine.sv =====
// quarter-wave sine/cosine lookup with quadrant folding
// depends on sqvs_pkg
module sqvs_sine #(
  parameter int SINE_TABLE_DEPTH = sqvs_pkg::SineTableDepth
) (
  input  logic [15:0]          angle_i,
  output sqvs_pkg::trig_t      sin_o,
  output sqvs_pkg::trig_t      cos_o
);
  localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PW = 14 + IW;

  logic [16:0] rom [SINE_TABLE_DEPTH + 1];

  for (genvar i = 0; i <= SINE_TABLE_DEPTH; i++) begin : g_rom
    localparam logic [63:0] P = (64'(i) << 32) / SINE_TABLE_DEPTH;
    assign rom[i] = sqvs_pkg::quarter_sine(P);
  end

  function automatic sqvs_pkg::trig_t lookup(input logic [15:0] a);
    logic [PW-1:0] prod;
    logic [IW-1:0] idx;
    logic [16:0]   ent;
    prod = PW'(a[13:0]) * PW'(SINE_TABLE_DEPTH) + PW'(8192);
    idx = prod[PW-1:14];
    if (idx > IW'(SINE_TABLE_DEPTH)) idx = IW'(SINE_TABLE_DEPTH);
    if (a[14]) idx = IW'(SINE_TABLE_DEPTH) - idx;
    ent = rom[idx];
    return a[15] ? -$signed({1'b0, ent}) : $signed({1'b0, ent});
  endfunction

  // table reads inside the function keep this block sensitive to the table
  always_comb begin
    sin_o = lookup(angle_i);
    cos_o = lookup(angle_i + 16'h4000);
  end
endmodule

// ===== src/sqvs_tex_div.sv =====
// pipelined restoring divider for one texture coordinate, four quotient bits a stage
// depends on sqvs_pkg
module sqvs_tex_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [11:0] src_i,
  input  logic [12:0] size_i,
  output logic [sqvs_pkg::DivBits-1:0] quo_o
);
  localparam int NB = sqvs_pkg::DivBits;
  localparam int NS = sqvs_pkg::DivStages;

  logic [12:0]   rem_q [NS];
  logic [NB-1:0] num_q [NS];
  logic [NB-1:0] quo_q [NS];
  logic [12:0]   rem_d [NS];
  logic [NB-1:0] num_d [NS];
  logic [NB-1:0] quo_d [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    always_comb begin : step
      logic [12:0]   r;
      logic [NB-1:0] n;
      logic [NB-1:0] q;
      logic [13:0]   tr;
      if (s == 0) begin
        // rounded dividend: src * 65536 + size / 2
        r = 13'd0;
        n = {src_i, 16'd0} + NB'(size_i >> 1);
        q = '0;
      end else begin
        r = rem_q[s-1];
        n = num_q[s-1];
        q = quo_q[s-1];
      end
      for (int b = 0; b < sqvs_pkg::DivStep; b++) begin
        tr = {r, n[NB-1]};
        n = {n[NB-2:0], 1'b0};
        if (tr >= {1'b0, size_i}) begin
          tr = tr - {1'b0, size_i};
          q = {q[NB-2:0], 1'b1};
        end else begin
          q = {q[NB-2:0], 1'b0};
        end
        r = tr[12:0];
      end
      rem_d[s] = r;
      num_d[s] = n;
      quo_d[s] = q;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d[s];
        num_q[s] <= num_d[s];
        quo_q[s] <= quo_d[s];
      end
    end
  end

  assign quo_o = quo_q[NS-1];
endmodule

// ===== src/sqvs_xform.sv =====
// corner rotation pipeline: local corners, products, sums, round and saturate, delay
// depends on sqvs_pkg and sqvs_sine
module sqvs_xform #(
  parameter int SINE_TABLE_DEPTH = sqvs_pkg::SineTableDepth
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [23:0] dst_left_i,
  input  logic signed [23:0] dst_top_i,
  input  logic signed [23:0] dst_right_i,
  input  logic signed [23:0] dst_bottom_i,
  input  logic [15:0]        rotation_i,
  input  logic signed [23:0] offset_x_i,
  input  logic signed [23:0] offset_y_i,
  output sqvs_pkg::quad_pos_t pos_o
);
  // three math stages, the rest is delay up to the full pipeline depth
  localparam int NDly = sqvs_pkg::PipeDepth - 3;

  sqvs_pkg::trig_t sin_d, cos_d, sin_q, cos_q;
  logic signed [24:0] dw, dh;
  logic signed [25:0] lx_q [2];
  logic signed [25:0] ly_q [2];
  logic signed [24:0] cx_q, cy_q, cx2_q, cy2_q;
  logic signed [43:0] pxc_q [2];
  logic signed [43:0] pxs_q [2];
  logic signed [43:0] pyc_q [2];
  logic signed [43:0] pys_q [2];
  logic signed [47:0] sx_q [4];
  logic signed [47:0] sy_q [4];
  sqvs_pkg::quad_pos_t pos_d;
  sqvs_pkg::quad_pos_t dly_q [NDly];

  sqvs_sine #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sine (
    .angle_i(rotation_i),
    .sin_o  (sin_d),
    .cos_o  (cos_d)
  );

  assign dw = 25'(dst_right_i) - 25'(dst_left_i);
  assign dh = 25'(dst_bottom_i) - 25'(dst_top_i);

  // stage 1: doubled local corners and centre
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q   <= sin_d;
      cos_q   <= cos_d;
      lx_q[0] <= -26'(dw) + (26'(offset_x_i) <<< 1);
      lx_q[1] <= 26'(dw) + (26'(offset_x_i) <<< 1);
      ly_q[0] <= -26'(dh) + (26'(offset_y_i) <<< 1);
      ly_q[1] <= 26'(dh) + (26'(offset_y_i) <<< 1);
      cx_q    <= 25'(dst_left_i) + 25'(dst_right_i);
      cy_q    <= 25'(dst_top_i) + 25'(dst_bottom_i);
    end
  end

  // stage 2: products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 2; i++) begin
        pxc_q[i] <= 44'(lx_q[i]) * 44'(cos_q);
        pxs_q[i] <= 44'(lx_q[i]) * 44'(sin_q);
        pyc_q[i] <= 44'(ly_q[i]) * 44'(cos_q);
        pys_q[i] <= 44'(ly_q[i]) * 44'(sin_q);
      end
      cx2_q <= cx_q;
      cy2_q <= cy_q;
    end
  end

  // stage 3: sums per distinct corner
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 4; k++) begin
        sx_q[k] <= 48'(pxc_q[k%2]) - 48'(pys_q[k/2]) + (48'(cx2_q) <<< 16);
        sy_q[k] <= 48'(pxs_q[k%2]) + 48'(pyc_q[k/2]) + (48'(cy2_q) <<< 16);
      end
    end
  end

  // stage 4: round half up to q16.8 and saturate
  function automatic sqvs_pkg::coord_t rnd_sat(input logic signed [47:0] v);
    logic signed [47:0] r;
    r = (v + 48'sd65536) >>> 17;
    if (r > 48'sd8388607) return 24'sd8388607;
    if (r < -48'sd8388608) return -24'sd8388608;
    return r[23:0];
  endfunction

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pos_d.x[k] = rnd_sat(sx_q[k]);
      pos_d.y[k] = rnd_sat(sy_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dly_q[0] <= pos_d;
      for (int i = 1; i < NDly; i++) dly_q[i] <= dly_q[i-1];
    end
  end

  assign pos_o = dly_q[NDly-1];
endmodule

// ===== src/sqvs_emit.sv =====
// vertex emitter: holds one finished sprite and sends its six vertices
// depends on sqvs_pkg and the out channel interface
module sqvs_emit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                take_o,
  input  sqvs_pkg::quad_pos_t pos_i,
  input  sqvs_pkg::texc_t     tu_i [2],
  input  sqvs_pkg::texc_t     tv_i [2],
  input  logic [31:0]         rgba_i,
  sqvs_out_if.source          out_o
);
  logic                full_q;
  logic [2:0]          cnt_q;
  sqvs_pkg::quad_pos_t pos_q;
  sqvs_pkg::texc_t     tu_q [2];
  sqvs_pkg::texc_t     tv_q [2];
  logic [31:0]         rgba_q;
  logic                fire, done, a, b;

  assign fire   = out_o.valid && out_o.ready;
  assign done   = fire && (cnt_q == sqvs_pkg::LastCorner);
  assign take_o = valid_i && (!full_q || done);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      if (take_o) full_q <= 1'b1;
      else if (done) full_q <= 1'b0;
      if (done) cnt_q <= 3'd0;
      else if (fire) cnt_q <= cnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      pos_q  <= pos_i;
      tu_q   <= tu_i;
      tv_q   <= tv_i;
      rgba_q <= rgba_i;
    end
  end

  assign a = sqvs_pkg::corner_col(cnt_q);
  assign b = sqvs_pkg::corner_row(cnt_q);

  assign out_o.valid       = full_q;
  assign out_o.vertex_x    = pos_q.x[{b, a}];
  assign out_o.vertex_y    = pos_q.y[{b, a}];
  assign out_o.tex_u       = tu_q[a];
  assign out_o.tex_v       = tv_q[b];
  assign out_o.color_rgba  = rgba_q;
  assign out_o.corner      = cnt_q;
  assign out_o.last_vertex = (cnt_q == sqvs_pkg::LastCorner);
endmodule

// ===== src/sprite_quad_vertex_setup_top.sv =====
// an accepted sprite crosses the pipeline and emitter register to its first vertex, then one
// vertex a cycle while the output is ready; the single vertex output sets the sprite rate;
// the 8-stage pipeline (seven divider stages plus saturation) waits only on a busy emitter
// reset: asynchronous active low, clears valid bits and emitter state, registers to 1
// depends on sqvs_pkg, sqvs_if, sqvs_cfg, sqvs_tex_div, sqvs_xform, sqvs_emit
module sprite_quad_vertex_setup_top #(
  parameter int SINE_TABLE_DEPTH = sqvs_pkg::SineTableDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  sqvs_in_if.sink     in_i,
  sqvs_out_if.source  out_o
);
  localparam int ND = sqvs_pkg::PipeDepth;
  localparam int NB = sqvs_pkg::DivBits;

  sqvs_pkg::tex_cfg_t  cfg;
  sqvs_pkg::quad_pos_t pos;
  sqvs_pkg::texc_t     tu_q [2];
  sqvs_pkg::texc_t     tv_q [2];
  logic [ND-1:0]       vld_q;
  logic [31:0]         rgba_q [ND];
  logic [NB-1:0]       quo [4];
  logic                adv, take;

  sqvs_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  // whole pipeline moves together; it stops only when the last stage cannot hand off
  assign adv        = !vld_q[ND-1] || take;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[ND-2:0], in_i.valid};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rgba_q[0] <= {in_i.tint_argb[23:0], in_i.tint_argb[31:24]};
      for (int i = 1; i < ND; i++) rgba_q[i] <= rgba_q[i-1];
    end
  end

  sqvs_tex_div u_div_l (.clk_i, .en_i(adv), .src_i(in_i.src_left),
                        .size_i(cfg.tex_width), .quo_o(quo[0]));
  sqvs_tex_div u_div_r (.clk_i, .en_i(adv), .src_i(in_i.src_right),
                        .size_i(cfg.tex_width), .quo_o(quo[1]));
  sqvs_tex_div u_div_t (.clk_i, .en_i(adv), .src_i(in_i.src_top),
                        .size_i(cfg.tex_height), .quo_o(quo[2]));
  sqvs_tex_div u_div_b (.clk_i, .en_i(adv), .src_i(in_i.src_bottom),
                        .size_i(cfg.tex_height), .quo_o(quo[3]));

  // saturate texture coordinates; v = 1 - ratio
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 2; i++) begin
        tu_q[i] <= (quo[i] > NB'(131071)) ? 18'sd131071 : quo[i][17:0];
        tv_q[i] <= (quo[2+i] > NB'(196608)) ? -18'sd131072
                                            : 18'(29'sd65536 - $signed({1'b0, quo[2+i]}));
      end
    end
  end

  sqvs_xform #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_xform (
    .clk_i,
    .en_i        (adv),
    .dst_left_i  (in_i.dst_left),
    .dst_top_i   (in_i.dst_top),
    .dst_right_i (in_i.dst_right),
    .dst_bottom_i(in_i.dst_bottom),
    .rotation_i  (in_i.rotation),
    .offset_x_i  (in_i.offset_x),
    .offset_y_i  (in_i.offset_y),
    .pos_o       (pos)
  );

  sqvs_emit u_emit (
    .clk_i, .rst_ni,
    .valid_i(vld_q[ND-1]),
    .take_o (take),
    .pos_i  (pos),
    .tu_i   (tu_q),
    .tv_i   (tv_q),
    .rgba_i (rgba_q[ND-1]),
    .out_o  (out_o)
  );
endmodule

// ===== tb/sprite_quad_vertex_setup_top_tb.sv =====
// self-checking bench for sprite_quad_vertex_setup_top: sprites in, six vertices out
// depends on sqvs_pkg, sqvs_if and the rtl top; predicts every vertex and scores it in order
module sprite_quad_vertex_setup_top_tb;

  typedef sqvs_pkg::coord_t coord_t;
  typedef sqvs_pkg::texc_t  texc_t;

  localparam int TableDepth = sqvs_pkg::SineTableDepth;
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;
  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 20;
  localparam logic [2:0] AddrTexWidth  = 3'(int'(sqvs_pkg::RegTexWidth) * 4);
  localparam logic [2:0] AddrTexHeight = 3'(int'(sqvs_pkg::RegTexHeight) * 4);

  typedef struct {
    logic [11:0] src_l, src_t, src_r, src_b;
    coord_t      dst_l, dst_t, dst_r, dst_b;
    logic [31:0] argb;
    logic [15:0] rot;
    coord_t      off_x, off_y;
  } sprite_t;

  typedef struct {
    coord_t      x, y;
    texc_t       u, v;
    logic [31:0] rgba;
    logic [2:0]  corner;
    logic        last;
  } vertex_t;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  sqvs_in_if  in_if();
  sqvs_out_if out_if();

  sprite_quad_vertex_setup_top u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_i(in_if.sink), .out_o(out_if.source)
  );

  vertex_t expected_vertices[$];
  logic [12:0] tex_width_q, tex_height_q;
  bit idle_en;
  int mismatches;
  int cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------- predictor ----------------
  function automatic longint quarter_wave_q16(int unsigned i);
    longint unsigned p, x, x2, t, sum, r;
    p = (longint'(i) << 32) / TableDepth;
    x = (p * HalfPiQ30) >> 32;
    x2 = (x * x) >> 30;
    t = x;
    sum = x;
    for (int k = 1; k <= 7; k++) begin
      t = ((t * x2) >> 30) / ((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum = sum - t;
      else sum = sum + t;
    end
    r = (sum + 8192) >> 14;
    return (r > 65536) ? 65536 : longint'(r);
  endfunction

  function automatic longint sine_q16(logic [15:0] angle);
    int unsigned idx;
    longint s;
    idx = (int'(angle[13:0]) * TableDepth + 8192) >> 14;
    if (idx > TableDepth) idx = TableDepth;
    if (angle[14]) idx = TableDepth - idx;
    s = quarter_wave_q16(idx);
    return angle[15] ? -s : s;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint tex_ratio(logic [11:0] src, logic [12:0] size);
    longint d;
    d = (size == 0) ? 1 : longint'(size);
    return (longint'(src) * 65536 + d / 2) / d;
  endfunction

  function automatic void predict_vertices(sprite_t sp);
    longint dl, dt, dr, db, s, c, cx2, cy2, px, py;
    longint lx[2], ly[2], tu[2], tv[2];
    int col, row;
    vertex_t vtx;
    dl = sp.dst_l; dt = sp.dst_t; dr = sp.dst_r; db = sp.dst_b;
    s = sine_q16(sp.rot);
    c = sine_q16(sp.rot + 16'h4000);
    cx2 = dl + dr;
    cy2 = dt + db;
    // corners in doubled units
    lx[0] = -(dr - dl) + 2 * longint'(sp.off_x);
    lx[1] = (dr - dl) + 2 * longint'(sp.off_x);
    ly[0] = -(db - dt) + 2 * longint'(sp.off_y);
    ly[1] = (db - dt) + 2 * longint'(sp.off_y);
    tu[0] = clamp(tex_ratio(sp.src_l, tex_width_q), -131072, 131071);
    tu[1] = clamp(tex_ratio(sp.src_r, tex_width_q), -131072, 131071);
    tv[0] = clamp(65536 - tex_ratio(sp.src_t, tex_height_q), -131072, 131071);
    tv[1] = clamp(65536 - tex_ratio(sp.src_b, tex_height_q), -131072, 131071);
    for (int k = 0; k < 6; k++) begin
      col = (k == 1 || k == 3 || k == 4) ? 1 : 0;
      row = (k == 2 || k == 4 || k == 5) ? 1 : 0;
      px = lx[col] * c - ly[row] * s + cx2 * 65536;
      py = lx[col] * s + ly[row] * c + cy2 * 65536;
      vtx.x = coord_t'(clamp((px + 65536) >>> 17, -8388608, 8388607));
      vtx.y = coord_t'(clamp((py + 65536) >>> 17, -8388608, 8388607));
      vtx.u = texc_t'(tu[col]);
      vtx.v = texc_t'(tv[row]);
      vtx.rgba = {sp.argb[23:0], sp.argb[31:24]};
      vtx.corner = 3'(k);
      vtx.last = (k == 5);
      expected_vertices.insert(expected_vertices.size(), vtx);
    end
  endfunction

  // ---------------- drivers ----------------
  task automatic send_sprite(sprite_t sp);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.src_left   <= sp.src_l;
    in_if.src_top    <= sp.src_t;
    in_if.src_right  <= sp.src_r;
    in_if.src_bottom <= sp.src_b;
    in_if.dst_left   <= sp.dst_l;
    in_if.dst_top    <= sp.dst_t;
    in_if.dst_right  <= sp.dst_r;
    in_if.dst_bottom <= sp.dst_b;
    in_if.tint_argb  <= sp.argb;
    in_if.rotation   <= sp.rot;
    in_if.offset_x   <= sp.off_x;
    in_if.offset_y   <= sp.off_y;
    do @(posedge clk_i); while (!in_if.ready);
    predict_vertices(sp);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (expected_vertices.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [12:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == AddrTexWidth) tex_width_q = value;
    else tex_height_q = value;
  endtask

  task automatic set_texture(logic [12:0] w, logic [12:0] h);
    wait_idle();
    write_reg(AddrTexWidth, w);
    write_reg(AddrTexHeight, h);
  endtask

  // well-formed sprite: modest rectangle, random content
  function automatic sprite_t plain_sprite();
    sprite_t sp;
    sp.src_l = 12'($urandom_range(0, 2047));
    sp.src_t = 12'($urandom_range(0, 2047));
    sp.src_r = sp.src_l + 12'($urandom_range(0, 2048));
    sp.src_b = sp.src_t + 12'($urandom_range(0, 2048));
    sp.dst_l = coord_t'($urandom_range(0, 1 << 20)) - coord_t'(1 << 19);
    sp.dst_t = coord_t'($urandom_range(0, 1 << 20)) - coord_t'(1 << 19);
    sp.dst_r = sp.dst_l + coord_t'($urandom_range(0, 1 << 16));
    sp.dst_b = sp.dst_t + coord_t'($urandom_range(0, 1 << 16));
    sp.argb = $urandom;
    sp.rot = 16'($urandom);
    sp.off_x = coord_t'($urandom_range(0, 1 << 12)) - coord_t'(1 << 11);
    sp.off_y = coord_t'($urandom_range(0, 1 << 12)) - coord_t'(1 << 11);
    return sp;
  endfunction

  function automatic sprite_t wild_sprite();
    sprite_t sp;
    sp.src_l = 12'($urandom); sp.src_t = 12'($urandom);
    sp.src_r = 12'($urandom); sp.src_b = 12'($urandom);
    sp.dst_l = coord_t'($urandom); sp.dst_t = coord_t'($urandom);
    sp.dst_r = coord_t'($urandom); sp.dst_b = coord_t'($urandom);
    sp.argb = $urandom;
    sp.rot = 16'($urandom);
    sp.off_x = coord_t'($urandom); sp.off_y = coord_t'($urandom);
    return sp;
  endfunction

  // ---------------- tests ----------------
  task automatic test_directed_corners();
    sprite_t sp;
    logic [15:0] angles[6] = '{16'h0000, 16'h2000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF};
    foreach (angles[i]) begin
      sp = plain_sprite();
      sp.rot = angles[i];
      send_sprite(sp);
    end
    // field extremes, saturating positions
    sp = wild_sprite();
    sp.src_l = 12'h000; sp.src_t = 12'h000; sp.src_r = 12'hFFF; sp.src_b = 12'hFFF;
    sp.dst_l = coord_t'(-8388608); sp.dst_t = coord_t'(-8388608);
    sp.dst_r = coord_t'(8388607); sp.dst_b = coord_t'(8388607);
    sp.argb = 32'hFFFF_FFFF; sp.rot = 16'h6000;
    sp.off_x = coord_t'(8388607); sp.off_y = coord_t'(-8388608);
    send_sprite(sp);
    sp.dst_l = coord_t'(8388607); sp.dst_r = coord_t'(-8388608);
    sp.dst_t = coord_t'(8388607); sp.dst_b = coord_t'(-8388608);
    sp.argb = 32'h0000_0000; sp.off_x = coord_t'(-8388608); sp.off_y = coord_t'(8388607);
    send_sprite(sp);
    // mirrored rectangles and an empty source
    sp = plain_sprite();
    {sp.dst_l, sp.dst_r} = {sp.dst_r, sp.dst_l};
    {sp.src_t, sp.src_b} = {sp.src_b, sp.src_t};
    send_sprite(sp);
    sp = plain_sprite();
    sp.src_r = sp.src_l; sp.src_b = sp.src_t;
    sp.dst_r = sp.dst_l; sp.dst_b = sp.dst_t;
    send_sprite(sp);
  endtask

  task automatic test_texture_sizes();
    logic [12:0] sizes[5] = '{13'd0, 13'd1, 13'd4096, 13'd8191, 13'd3};
    foreach (sizes[i]) begin
      set_texture(sizes[i], sizes[(i + 2) % 5]);
      repeat (3) send_sprite(wild_sprite());
    end
  endtask

  task automatic test_random_mix(int count);
    for (int n = 0; n < count; n++) begin
      if (n % 30 == 29) set_texture(13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)));
      send_sprite($urandom_range(0, 3) == 0 ? wild_sprite() : plain_sprite());
    end
  endtask

  task automatic test_full_rate(int count);
    wait_idle();
    idle_en = 1'b0;
    repeat (count) send_sprite(plain_sprite());
  endtask

  // ---------------- sink side ----------------
  initial begin
    out_if.ready = 1'b1;
    forever begin
      @(posedge clk_i);
      if (idle_en && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    vertex_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_vertices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected vertex corner %0d", out_if.corner);
      end else begin
        want = expected_vertices.pop_front();
        if (out_if.vertex_x !== want.x || out_if.vertex_y !== want.y ||
            out_if.tex_u !== want.u || out_if.tex_v !== want.v ||
            out_if.color_rgba !== want.rgba || out_if.corner !== want.corner ||
            out_if.last_vertex !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("vertex mismatch exp x=%0d y=%0d u=%0d v=%0d c=%h k=%0d l=%b",
                     want.x, want.y, want.u, want.v, want.rgba, want.corner, want.last);
            $display("                got x=%0d y=%0d u=%0d v=%0d c=%h k=%0d l=%b",
                     out_if.vertex_x, out_if.vertex_y, out_if.tex_u, out_if.tex_v,
                     out_if.color_rgba, out_if.corner, out_if.last_vertex);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    cycles = 0;
    mismatches = 0;
    idle_en = 1'b1;
    tex_width_q = 13'd1;
    tex_height_q = 13'd1;
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_if.valid = 1'b0;
    in_if.src_left = '0; in_if.src_top = '0; in_if.src_right = '0; in_if.src_bottom = '0;
    in_if.dst_left = '0; in_if.dst_top = '0; in_if.dst_right = '0; in_if.dst_bottom = '0;
    in_if.tint_argb = '0; in_if.rotation = '0; in_if.offset_x = '0; in_if.offset_y = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_corners();
    test_texture_sizes();
    test_random_mix(70);
    test_full_rate(25);
    wait_idle();
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
src/sqvs_pkg.sv
src/sqvs_if.sv
src/sqvs_cfg.sv
src/sqvs_sine.sv
src/sqvs_tex_div.sv
src/sqvs_xform.sv
src/sqvs_emit.sv
src/sprite_quad_vertex_setup_top.sv
tb/sprite_quad_vertex_setup_top_tb.sv
